/* rtl/core/setq_pkg.sv */
// Shared types and constants of the sorted expiry timer queue.
`default_nettype none

package setq_pkg;

	// Request codes on req_type.
	localparam logic [1:0] REQ_ARM    = 2'd0;
	localparam logic [1:0] REQ_CANCEL = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// Placement codes for an arm result.
	localparam logic [1:0] PLACE_EMPTY  = 2'd0;
	localparam logic [1:0] PLACE_HEAD   = 2'd1;
	localparam logic [1:0] PLACE_BEHIND = 2'd2;

	// Expiry length used in place of a negative one.
	localparam logic [31:0] NEG_LEN_SUBST = 32'd3;

	// Most expired timers reported by one tick.
	localparam int MAX_RESULTS = 16;
	localparam int K_W         = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		KIND_ARMED     = 3'd0,
		KIND_CANCELLED = 3'd1,
		KIND_NOT_FOUND = 3'd2,
		KIND_EXPIRED   = 3'd3,
		KIND_IDLE_TICK = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DEQ,
		ST_INS,
		ST_EMIT,
		ST_TK_CHECK,
		ST_TK_LOAD,
		ST_TK_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  accept;
		logic  pass_init;
		logic  pass_run;
		logic  pass_ins;
		logic  deq_commit;
		logic  ins_commit;
		logic  pop;
		logic  head_load;
		logic  emit;
		kind_t emit_kind;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] req_type;
		logic       id_ok;
		logic       id_queued;
		logic       pass_done;
		logic       tick_more;
		logic       out_free;
	} status_t;

endpackage

`default_nettype wire

/* rtl/core/sorted_expiry_timer_queue.sv */
// Top level of the sorted expiry timer queue: controller and datapath.
`default_nettype none

// Keeps up to NUM_TIMERS timers in a list ordered by expiry time; timers with
// equal expiry stay in arming order. Word types on req_type: arm (remove the
// timer if queued, then queue it to expire at now + length, with a negative
// length taken as 3), cancel (remove and report whether it was queued) and
// tick (advance the time counter by one and report every expired timer, head
// first, at most 16 per tick; the rest go out on the next tick). All time
// compares use the wrap-safe signed difference of TIME_WIDTH-bit values.
// Every result word carries the head expiry after that result and whether
// any timer remains queued; last marks the final word of a request.
// One request is handled at a time; in_stall is high from acceptance until
// the final result word has been loaded into the output register, which
// holds it while out_stall is high. The ordered list lives in a circular
// memory with one read and one write port that is scanned one entry per
// cycle. Re-arming a queued timer adds a removal pass ahead of the insertion
// into the remaining entries. Removing an expired timer from the head only
// moves the circular base pointer. Memory entries beyond the fill count are
// never used, so there is no clearing pass after reset.
module sorted_expiry_timer_queue #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [3:0]         timer_id,
	input  wire logic signed [31:0] length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              result_kind,
	output logic [3:0]              result_id,
	output logic [1:0]              placement,
	output logic [31:0]             head_expiry,
	output logic                    queue_active,
	output logic                    last
);
	import setq_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequence each request: decode, scan passes, head pops, result word loads.
	setq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold the ordered list, the time counter and the output word register.
	setq_dp #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.timer_id     (timer_id),
		.length       (length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.result_id    (result_id),
		.placement    (placement),
		.head_expiry  (head_expiry),
		.queue_active (queue_active),
		.last         (last)
	);

endmodule

`default_nettype wire

/* rtl/core/setq_dp.sv */
// Datapath of the sorted expiry timer queue: order memory, counters, output word register.
`default_nettype none

module setq_dp #(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire setq_pkg::cmd_t     cmd,
	output setq_pkg::status_t       status,
	input  wire logic [1:0]         req_type,
	input  wire logic [3:0]         timer_id,
	input  wire logic signed [31:0] length,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              result_kind,
	output logic [3:0]              result_id,
	output logic [1:0]              placement,
	output logic [31:0]             head_expiry,
	output logic                    queue_active,
	output logic                    last
);
	import setq_pkg::*;

	localparam int ID_W  = $clog2(NUM_TIMERS);
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [TIME_WIDTH-1:0] exp;
	} entry_t;

	// True when time a lies strictly before time b, modulo wrap.
	function automatic logic time_before(input logic [TIME_WIDTH-1:0] a,
			input logic [TIME_WIDTH-1:0] b);
		logic [TIME_WIDTH-1:0] diff;
		diff = a - b;
		return diff[TIME_WIDTH-1];
	endfunction

	// Map a list position onto the circular memory.
	function automatic logic [ID_W-1:0] phys_addr(input logic [ID_W-1:0] base,
			input logic [CNT_W-1:0] lidx);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(lidx);
		if (sum >= SUM_W'(NUM_TIMERS)) begin
			sum = sum - SUM_W'(NUM_TIMERS);
		end
		return ID_W'(sum);
	endfunction

	// Request registers.
	logic [1:0]            req_type_q;
	logic [3:0]            req_id_q;
	logic [TIME_WIDTH-1:0] when_q;
	logic [TIME_WIDTH-1:0] now_q;
	logic [K_W-1:0]        k_q;

	// Queue state.
	logic [ID_W-1:0]       base_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_TIMERS-1:0] slot_queued_q;
	entry_t                head_q;
	logic [ID_W-1:0]       exp_id_q;
	logic [1:0]            place_q;

	// Scan pass.
	logic [CNT_W-1:0] rd_idx_q;
	logic             rv_s1;
	logic [CNT_W-1:0] tag_s1;
	logic             found_q;
	logic             found_zero_q;
	entry_t           carry_q;

	entry_t mem [NUM_TIMERS];
	entry_t rdata_s1;

	logic [31:0]      len_clamped;
	logic [ID_W-1:0]  slot_idx;
	logic             id_ok;
	entry_t           new_entry;
	logic             issue;
	logic             proc;
	logic [CNT_W-1:0] rd_lidx;
	logic [ID_W-1:0]  rd_addr;
	logic             wr_en;
	logic [CNT_W-1:0] wr_lidx;
	entry_t           wr_data;
	logic [ID_W-1:0]  wr_addr;
	logic             found_set;
	logic             found_zero_set;
	logic             carry_en;
	logic             tick_more;
	logic             out_free;

	assign len_clamped = length[31] ? NEG_LEN_SUBST : $unsigned(length);
	assign slot_idx    = ID_W'(req_id_q);
	assign id_ok       = 32'(req_id_q) < 32'(NUM_TIMERS);
	assign new_entry   = '{id: slot_idx, exp: when_q};
	assign issue       = cmd.pass_run && (rd_idx_q < cnt_q);
	assign proc        = cmd.pass_run && rv_s1;
	assign rd_lidx     = cmd.pop ? CNT_W'(1) : rd_idx_q;
	assign rd_addr     = phys_addr(base_q, rd_lidx);
	assign wr_addr     = phys_addr(base_q, wr_lidx);
	assign tick_more   = (cnt_q != '0) && !time_before(now_q, head_q.exp)
			&& (k_q < K_W'(MAX_RESULTS));
	assign out_free    = !out_valid || !out_stall;

	always_comb begin
		status.req_type  = req_type_q;
		status.id_ok     = id_ok;
		status.id_queued = id_ok && slot_queued_q[slot_idx];
		status.pass_done = (rd_idx_q == cnt_q) && !rv_s1;
		status.tick_more = tick_more;
		status.out_free  = out_free;
	end

	// Scan data handling: close the gap on removal, ripple entries down on insertion.
	always_comb begin
		wr_en          = 1'b0;
		wr_lidx        = '0;
		wr_data        = new_entry;
		found_set      = 1'b0;
		found_zero_set = 1'b0;
		carry_en       = 1'b0;
		if (proc && !cmd.pass_ins) begin
			if (found_q) begin
				wr_en   = 1'b1;
				wr_lidx = tag_s1 - CNT_W'(1);
				wr_data = rdata_s1;
			end
			if (rdata_s1.id == slot_idx) begin
				found_set = 1'b1;
			end
		end else if (proc && cmd.pass_ins) begin
			if (!found_q) begin
				if (time_before(when_q, rdata_s1.exp)) begin
					wr_en          = 1'b1;
					wr_lidx        = tag_s1;
					wr_data        = new_entry;
					found_set      = 1'b1;
					found_zero_set = (tag_s1 == '0);
					carry_en       = 1'b1;
				end
			end else begin
				wr_en    = 1'b1;
				wr_lidx  = tag_s1;
				wr_data  = carry_q;
				carry_en = 1'b1;
			end
		end else if (cmd.ins_commit) begin
			wr_en   = 1'b1;
			wr_lidx = cnt_q;
			wr_data = found_q ? carry_q : new_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_type_q <= req_type;
			req_id_q   <= timer_id;
			when_q     <= now_q + TIME_WIDTH'(len_clamped);
		end
		if (wr_en && wr_lidx == '0) begin
			head_q <= wr_data;
		end else if (cmd.head_load) begin
			head_q <= rdata_s1;
		end
		if (cmd.pop) begin
			exp_id_q <= head_q.id;
		end
		if (carry_en) begin
			carry_q <= rdata_s1;
		end
		tag_s1 <= rd_idx_q;
		if (cmd.ins_commit) begin
			if (cnt_q == '0) begin
				place_q <= PLACE_EMPTY;
			end else if (found_q && found_zero_q) begin
				place_q <= PLACE_HEAD;
			end else begin
				place_q <= PLACE_BEHIND;
			end
		end
		if (cmd.emit) begin
			result_kind <= cmd.emit_kind;
			case (cmd.emit_kind)
				KIND_EXPIRED:   result_id <= 4'(exp_id_q);
				KIND_IDLE_TICK: result_id <= 4'd0;
				default:        result_id <= req_id_q;
			endcase
			placement    <= (cmd.emit_kind == KIND_ARMED) ? place_q : PLACE_EMPTY;
			head_expiry  <= (cnt_q != '0) ? 32'(head_q.exp) : 32'd0;
			queue_active <= (cnt_q != '0);
			last         <= (cmd.emit_kind == KIND_EXPIRED) ? !tick_more : 1'b1;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q         <= '0;
			k_q           <= '0;
			base_q        <= '0;
			cnt_q         <= '0;
			slot_queued_q <= '0;
			rd_idx_q      <= '0;
			rv_s1         <= 1'b0;
			found_q       <= 1'b0;
			found_zero_q  <= 1'b0;
			out_valid     <= 1'b0;
		end else begin
			if (cmd.accept) begin
				k_q <= '0;
				if (req_type == REQ_TICK) begin
					now_q <= now_q + TIME_WIDTH'(1);
				end
			end
			if (cmd.deq_commit) begin
				cnt_q                   <= cnt_q - CNT_W'(1);
				slot_queued_q[slot_idx] <= 1'b0;
			end else if (cmd.ins_commit) begin
				cnt_q                   <= cnt_q + CNT_W'(1);
				slot_queued_q[slot_idx] <= 1'b1;
			end else if (cmd.pop) begin
				cnt_q                  <= cnt_q - CNT_W'(1);
				slot_queued_q[head_q.id] <= 1'b0;
				base_q <= (base_q == ID_W'(NUM_TIMERS - 1)) ? '0 : base_q + ID_W'(1);
				k_q    <= k_q + K_W'(1);
			end
			rv_s1 <= issue;
			if (cmd.pass_init) begin
				rd_idx_q     <= '0;
				found_q      <= 1'b0;
				found_zero_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (found_set) begin
					found_q <= 1'b1;
				end
				if (found_zero_set) begin
					found_zero_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_count_matches_bits: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_queued_q) == int'(cnt_q))
		else $error("queued bits disagree with fill count");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_commit |-> (cnt_q < CNT_W'(NUM_TIMERS)))
		else $error("insertion into a full queue");

	a_removal_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq_commit |-> found_q)
		else $error("removal pass ended without finding the timer");

endmodule

`default_nettype wire

/* rtl/core/setq_ctrl.sv */
// Controller state machine of the sorted expiry timer queue.
`default_nettype none

module setq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire setq_pkg::status_t status,
	output setq_pkg::cmd_t         cmd
);
	import setq_pkg::*;

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_ARMED;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		kind_d        = kind_q;
		cmd           = '0;
		cmd.emit_kind = kind_q;
		in_stall      = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.pass_init = 1'b1;
				unique case (status.req_type)
					REQ_ARM: begin
						kind_d = KIND_ARMED;
						if (!status.id_ok) begin
							state_d = ST_IDLE;
						end else if (status.id_queued) begin
							state_d = ST_DEQ;
						end else begin
							state_d = ST_INS;
						end
					end
					REQ_CANCEL: begin
						if (status.id_queued) begin
							kind_d  = KIND_CANCELLED;
							state_d = ST_DEQ;
						end else begin
							kind_d  = KIND_NOT_FOUND;
							state_d = ST_EMIT;
						end
					end
					REQ_TICK: begin
						state_d = ST_TK_CHECK;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DEQ: begin
				cmd.pass_run = 1'b1;
				if (status.pass_done) begin
					cmd.deq_commit = 1'b1;
					cmd.pass_init  = 1'b1;
					state_d = (status.req_type == REQ_ARM) ? ST_INS : ST_EMIT;
				end
			end
			ST_INS: begin
				cmd.pass_run = 1'b1;
				cmd.pass_ins = 1'b1;
				if (status.pass_done) begin
					cmd.ins_commit = 1'b1;
					state_d        = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_TK_CHECK: begin
				if (status.tick_more) begin
					cmd.pop = 1'b1;
					state_d = ST_TK_LOAD;
				end else begin
					kind_d  = KIND_IDLE_TICK;
					state_d = ST_EMIT;
				end
			end
			ST_TK_LOAD: begin
				cmd.head_load = 1'b1;
				state_d       = ST_TK_EMIT;
			end
			ST_TK_EMIT: begin
				cmd.emit_kind = KIND_EXPIRED;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = status.tick_more ? ST_TK_CHECK : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_emit_into_free_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("result word loaded over an untaken one");

endmodule

`default_nettype wire

/* tb/sorted_expiry_timer_queue_tb.sv */
// Self-checking testbench for the sorted expiry timer queue.
`default_nettype none

module sorted_expiry_timer_queue_tb;
	import setq_pkg::*;

	localparam int SLOTS       = 16;
	localparam int CYCLE_LIMIT = 600000;
	// Settle time after the last expected word, so that a request that makes
	// no word (the unused code) has finished before the next phase starts.
	localparam int SETTLE      = 64;

	// The one request code the block ignores; no word comes back for it.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Placement field value for every word that is not an arm report.
	localparam logic [1:0] PLACE_NONE = 2'd0;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  id;
		logic [1:0]  place;
		logic [31:0] head;
		logic        active;
		logic        last;
	} timer_word_t;

	// Mirror of the timer list plus the queue of words it says must come out.
	class timer_queue_tracker;
		logic [31:0] clock_now;
		logic [31:0] expiry_at [SLOTS];
		bit          armed [SLOTS];
		logic [3:0]  order [$];
		timer_word_t due_words [$];
		int fails = 0;
		int n_arm = 0, n_cancel = 0, n_tick = 0, n_expired = 0, n_checked = 0;

		function new();
			clock_now = '0;
			foreach (armed[i]) begin
				armed[i] = 1'b0;
				expiry_at[i] = '0;
			end
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		// Wrap-safe "a strictly before b".
		function bit earlier(logic [31:0] a, logic [31:0] b);
			logic [31:0] diff;
			diff = a - b;
			return diff[31];
		endfunction

		function void unlink(logic [3:0] id);
			for (int i = 0; i < order.size(); i++) begin
				if (order[i] == id) begin
					order.delete(i);
					break;
				end
			end
			armed[id] = 1'b0;
		endfunction

		function void queue_word(logic [2:0] kind, logic [3:0] id, logic [1:0] place,
				bit is_last);
			timer_word_t w;
			w.kind = kind;
			w.id = id;
			w.place = place;
			w.head = order.size() ? expiry_at[order[0]] : 32'd0;
			w.active = (order.size() != 0);
			w.last = is_last;
			due_words.push_back(w);
		endfunction

		function void note_request(logic [1:0] req, logic [3:0] id, logic signed [31:0] len);
			logic [31:0] stretch, when;
			logic [1:0]  place;
			int          pos, k;
			logic [3:0]  head_id;
			timer_word_t tail;
			case (req)
				REQ_ARM: begin
					n_arm++;
					if (armed[id])
						unlink(id);
					if (len < 0)
						stretch = NEG_LEN_SUBST;
					else
						stretch = len;
					when = clock_now + stretch;
					expiry_at[id] = when;
					if (order.size() == 0) begin
						place = PLACE_EMPTY;
						pos = 0;
					end else if (earlier(when, expiry_at[order[0]])) begin
						place = PLACE_HEAD;
						pos = 0;
					end else begin
						// behind every timer with the same expiry
						place = PLACE_BEHIND;
						pos = order.size();
						for (int i = 1; i < order.size(); i++) begin
							if (earlier(when, expiry_at[order[i]])) begin
								pos = i;
								break;
							end
						end
					end
					order.insert(pos, id);
					armed[id] = 1'b1;
					queue_word(KIND_ARMED, id, place, 1'b1);
				end
				REQ_CANCEL: begin
					n_cancel++;
					if (armed[id]) begin
						unlink(id);
						queue_word(KIND_CANCELLED, id, PLACE_NONE, 1'b1);
					end else begin
						queue_word(KIND_NOT_FOUND, id, PLACE_NONE, 1'b1);
					end
				end
				REQ_TICK: begin
					n_tick++;
					clock_now = clock_now + 32'd1;
					k = 0;
					while (order.size() != 0 && k < MAX_RESULTS &&
							!earlier(clock_now, expiry_at[order[0]])) begin
						head_id = order[0];
						unlink(head_id);
						queue_word(KIND_EXPIRED, head_id, PLACE_NONE, 1'b0);
						k++;
					end
					n_expired += k;
					if (k == 0) begin
						queue_word(KIND_IDLE_TICK, 4'd0, PLACE_NONE, 1'b1);
					end else begin
						tail = due_words.pop_back();
						tail.last = 1'b1;
						due_words.push_back(tail);
					end
				end
				default: ;
			endcase
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				fails++;
			end
		endfunction

		function void check_result(timer_word_t got);
			timer_word_t want;
			if (due_words.size() == 0) begin
				$error("unexpected result word: kind %0d id %0d", got.kind, got.id);
				fails++;
				return;
			end
			want = due_words.pop_front();
			n_checked++;
			cmp_field("result_kind", 32'(want.kind), 32'(got.kind));
			cmp_field("result_id", 32'(want.id), 32'(got.id));
			cmp_field("placement", 32'(want.place), 32'(got.place));
			cmp_field("head_expiry", want.head, got.head);
			cmp_field("queue_active", 32'(want.active), 32'(got.active));
			cmp_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [3:0]         timer_id;
	logic signed [31:0] length;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         result_kind;
	logic [3:0]         result_id;
	logic [1:0]         placement;
	logic [31:0]        head_expiry;
	logic               queue_active;
	logic               last;

	timer_queue_tracker tracker = new();
	timer_word_t        seen_word;
	int                 send_idle_pct;
	int                 recv_idle_pct;
	int                 cycle_count = 0;

	sorted_expiry_timer_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.timer_id     (timer_id),
		.length       (length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.result_id    (result_id),
		.placement    (placement),
		.head_expiry  (head_expiry),
		.queue_active (queue_active),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Count cycles and end the run when the limit is hit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$error("timeout after %0d cycles, %0d words still due", cycle_count,
			tracker.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// Sample both handshakes at the rising edge: feed accepted requests into the
	// mirror, check every accepted result word against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_request(req_type, timer_id, length);
			if (out_valid && !out_stall) begin
				seen_word.kind = result_kind;
				seen_word.id = result_id;
				seen_word.place = placement;
				seen_word.head = head_expiry;
				seen_word.active = queue_active;
				seen_word.last = last;
				tracker.check_result(seen_word);
			end
		end
	end

	// Receiver: stall at random on the falling edge at the current phase's rate.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Present one request word and hold it until the block takes it. An idle
	// gap, if any, drops valid first; valid is only raised on a later edge.
	task automatic send_request(input logic [1:0] req, input logic [3:0] id,
			input logic [31:0] len);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type = req;
		timer_id = id;
		length = len;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Hold off the sender until every expected word has come back, then let the
	// block settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly well-formed traffic with random content: ticks, arms with short
	// lengths so timers do expire, cancels, and now and then a burst of arms
	// sharing one expiry so a single tick reports many timers. Unused request
	// codes are thrown in as noise and not counted.
	task automatic random_phase(input int goal);
		int          done, pick, cnt;
		logic [3:0]  base;
		logic [31:0] stretch;
		done = 0;
		while (done < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				cnt = $urandom_range(6, SLOTS);
				base = 4'($urandom);
				stretch = $urandom_range(0, 3);
				for (int j = 0; j < cnt; j++)
					send_request(REQ_ARM, 4'(base + j), stretch);
				for (int j = 0; j < 5; j++)
					send_request(REQ_TICK, 4'($urandom), $urandom);
				done += cnt + 5;
			end else if (pick < 12) begin
				send_request(REQ_UNUSED, 4'($urandom), $urandom);
			end else if (pick < 50) begin
				send_request(REQ_TICK, 4'($urandom), $urandom);
				done++;
			end else if (pick < 82) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					stretch = $urandom_range(0, 24);
				else if (pick < 85)
					stretch = {1'b1, 31'($urandom)};
				else
					stretch = $urandom;
				send_request(REQ_ARM, 4'($urandom), stretch);
				done++;
			end else begin
				send_request(REQ_CANCEL, 4'($urandom), $urandom);
				done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		timer_id = 4'd0;
		length = 32'sd0;
		send_idle_pct = 9;
		recv_idle_pct = 50;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-queue cancel and tick, the ignored code, each arm
		// placement, a tie on expiry, re-arm of a queued timer, negative and
		// extreme lengths, cancel hit and miss, then ticks through expiries.
		send_request(REQ_CANCEL, 4'd0, 32'd0);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF);
		send_request(REQ_ARM, 4'd5, 32'd10);
		send_request(REQ_ARM, 4'd6, 32'd2);
		send_request(REQ_ARM, 4'd7, 32'd10);
		send_request(REQ_ARM, 4'd5, 32'hFFFF_FFFF);
		send_request(REQ_CANCEL, 4'd6, 32'd0);
		send_request(REQ_ARM, 4'd15, 32'h7FFF_FFFF);
		send_request(REQ_ARM, 4'd0, 32'h8000_0000);
		send_request(REQ_ARM, 4'd1, 32'd0);
		send_request(REQ_CANCEL, 4'd9, 32'd0);
		repeat (4) send_request(REQ_TICK, 4'd0, 32'd0);
		drain_results();

		// Fill every slot with the same expiry so one tick reports them all.
		for (int j = 0; j < SLOTS; j++)
			send_request(REQ_ARM, 4'(j), 32'd1);
		send_request(REQ_TICK, 4'd0, 32'd0);
		send_request(REQ_TICK, 4'd0, 32'd0);
		drain_results();

		// Sender light, receiver heavy.
		random_phase(130);
		drain_results();

		// Sender heavy, receiver light.
		send_idle_pct = 50;
		recv_idle_pct = 9;
		random_phase(130);
		drain_results();

		// Back to back on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(130);
		drain_results();

		$display("covered %0d arms, %0d cancels, %0d ticks with %0d expiries reported",
			tracker.n_arm, tracker.n_cancel, tracker.n_tick, tracker.n_expired);
		$display("checked %0d result words over three idle mixes, %0d failures",
			tracker.n_checked, tracker.fails);
		if (tracker.fails == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
